/* hdl/rotated_centered_image_sampler_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rotated image sampler.
// ----------------------------------------------------------------------------
`ifndef ROTATED_CENTERED_IMAGE_SAMPLER_MACROS_SVH
`define ROTATED_CENTERED_IMAGE_SAMPLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCIS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/rcis_pkg.sv */
// ----------------------------------------------------------------------------
// Rotated image sampler package
// Field widths, register indexes, codes and control structures.
// ----------------------------------------------------------------------------
package rcis_pkg;

   localparam int KIND_W       = 1;
   localparam int LOAD_INDEX_W = 14;
   localparam int PIXEL_W      = 16;
   localparam int POS_W        = 10;
   localparam int SIZE_W       = 11;
   localparam int ROT_W        = 2;
   localparam int CSR_INDEX_W  = 3;

   // Bits needed to hold the widest size reset value.
   localparam int SIZE_RST_W = 9;

   localparam int FRAME_WIDTH_RST    = 320;
   localparam int FRAME_HEIGHT_RST   = 240;
   localparam int PICTURE_WIDTH_RST  = 128;
   localparam int PICTURE_HEIGHT_RST = 128;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROTATION_MODE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PICTURE_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PICTURE_HEIGHT = 3'd4;

   localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
   localparam logic [ROT_W-1:0] ROT_CW   = 2'd1;
   localparam logic [ROT_W-1:0] ROT_HALF = 2'd2;
   localparam logic [ROT_W-1:0] ROT_CCW  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
   localparam logic [KIND_W-1:0] KIND_READ = 1'b1;

   localparam logic [PIXEL_W-1:0] BLACK = 16'h0000;

   typedef struct packed {
      logic map_en;
      logic mul_en;
   } map_ctrl_type;

   typedef struct packed {
      logic in_pic;
      logic hit;
   } map_stat_type;

endpackage

/* hdl/rcis_csr.sv */
// ----------------------------------------------------------------------------
// Rotated image sampler configuration registers
// Holds the frame and picture sizes and the rotation mode, with size clamping.
// ----------------------------------------------------------------------------
module rcis_csr import rcis_pkg::*; #(
   parameter int MAX_DIM = 1024,
   parameter int DIM_W   = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]      csr_data,
   output logic [DIM_W-1:0]       frame_width,
   output logic [DIM_W-1:0]       frame_height,
   output logic [ROT_W-1:0]       rotation_mode,
   output logic [DIM_W-1:0]       picture_width,
   output logic [DIM_W-1:0]       picture_height
);

   logic [DIM_W-1:0] frame_width_ff;
   logic [DIM_W-1:0] frame_height_ff;
   logic [ROT_W-1:0] rotation_mode_ff;
   logic [DIM_W-1:0] picture_width_ff;
   logic [DIM_W-1:0] picture_height_ff;
   logic [DIM_W-1:0] size_clamped;

   always_comb begin
      if (32'(csr_data) > 32'(MAX_DIM)) begin
         size_clamped = DIM_W'(MAX_DIM);
      end else begin
         size_clamped = DIM_W'(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= DIM_W'(FRAME_WIDTH_RST);
         frame_height_ff   <= DIM_W'(FRAME_HEIGHT_RST);
         rotation_mode_ff  <= ROT_NONE;
         picture_width_ff  <= DIM_W'(PICTURE_WIDTH_RST);
         picture_height_ff <= DIM_W'(PICTURE_HEIGHT_RST);
      end else if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               frame_width_ff <= size_clamped;
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_ff <= size_clamped;
            end
            CSR_ROTATION_MODE: begin
               rotation_mode_ff <= csr_data[ROT_W-1:0];
            end
            CSR_PICTURE_WIDTH: begin
               picture_width_ff <= size_clamped;
            end
            CSR_PICTURE_HEIGHT: begin
               picture_height_ff <= size_clamped;
            end
            default: begin
            end
         endcase
      end
   end

   assign frame_width    = frame_width_ff;
   assign frame_height   = frame_height_ff;
   assign rotation_mode  = rotation_mode_ff;
   assign picture_width  = picture_width_ff;
   assign picture_height = picture_height_ff;

endmodule

/* hdl/rcis_map.sv */
// ----------------------------------------------------------------------------
// Rotated image sampler coordinate mapper
// Rotates and centres a framebuffer coordinate, then forms the store address.
// ----------------------------------------------------------------------------
module rcis_map import rcis_pkg::*; #(
   parameter int DIM_W        = 11,
   parameter int LIN_W        = 23,
   parameter int IMAGE_PIXELS = 16384
) (
   input  logic               clock,
   input  map_ctrl_type       ctrl,
   input  logic [POS_W-1:0]   pos_x,
   input  logic [POS_W-1:0]   pos_y,
   input  logic [DIM_W-1:0]   frame_width,
   input  logic [DIM_W-1:0]   frame_height,
   input  logic [ROT_W-1:0]   rotation_mode,
   input  logic [DIM_W-1:0]   picture_width,
   input  logic [DIM_W-1:0]   picture_height,
   output logic [LIN_W-1:0]   lin_addr,
   output map_stat_type       stat
);

   localparam int SW     = ((DIM_W > POS_W) ? DIM_W : POS_W) + 3;
   localparam int PROD_W = 2 * DIM_W;
   localparam logic signed [SW-1:0] ONE_S = SW'(1);

   logic signed [SW-1:0] fw_s;
   logic signed [SW-1:0] fh_s;
   logic signed [SW-1:0] pw_s;
   logic signed [SW-1:0] ph_s;
   logic signed [SW-1:0] x_s;
   logic signed [SW-1:0] y_s;
   logic signed [SW-1:0] scr_w;
   logic signed [SW-1:0] scr_h;
   logic signed [SW-1:0] dx;
   logic signed [SW-1:0] dy;
   logic signed [SW-1:0] dx_adj;
   logic signed [SW-1:0] dy_adj;
   logic signed [SW-1:0] off_x;
   logic signed [SW-1:0] off_y;
   logic signed [SW-1:0] rx;
   logic signed [SW-1:0] ry;
   logic signed [SW-1:0] sx;
   logic signed [SW-1:0] sy;
   logic                 outside;
   logic                 in_pic;

   logic [DIM_W-1:0]     sx_ff;
   logic [DIM_W-1:0]     sy_ff;
   logic                 inside_ff;
   logic [PROD_W-1:0]    prod;
   logic [LIN_W-1:0]     lin;
   logic                 hit;
   logic [LIN_W-1:0]     addr_ff;
   logic                 hit_ff;
   logic                 inside2_ff;

   always_comb begin
      fw_s = $signed(SW'(frame_width));
      fh_s = $signed(SW'(frame_height));
      pw_s = $signed(SW'(picture_width));
      ph_s = $signed(SW'(picture_height));
      x_s  = $signed(SW'(pos_x));
      y_s  = $signed(SW'(pos_y));

      outside = (x_s >= fw_s) || (y_s >= fh_s);

      scr_w = rotation_mode[0] ? fh_s : fw_s;
      scr_h = rotation_mode[0] ? fw_s : fh_s;

      // The shift rounds down; negative differences are bumped to round toward zero.
      dx     = scr_w - pw_s;
      dy     = scr_h - ph_s;
      dx_adj = dx + $signed(SW'(dx[SW-1]));
      dy_adj = dy + $signed(SW'(dy[SW-1]));
      off_x  = dx_adj >>> 1;
      off_y  = dy_adj >>> 1;

      case (rotation_mode)
         ROT_CW: begin
            rx = fh_s - ONE_S - y_s;
            ry = x_s;
         end
         ROT_HALF: begin
            rx = fw_s - ONE_S - x_s;
            ry = fh_s - ONE_S - y_s;
         end
         ROT_CCW: begin
            rx = y_s;
            ry = fw_s - ONE_S - x_s;
         end
         default: begin
            rx = x_s;
            ry = y_s;
         end
      endcase

      sx = rx - off_x;
      sy = ry - off_y;

      in_pic = !outside && !sx[SW-1] && (sx < pw_s) && !sy[SW-1] && (sy < ph_s);
   end

   always_ff @(posedge clock) begin
      if (ctrl.map_en) begin
         sx_ff     <= sx[DIM_W-1:0];
         sy_ff     <= sy[DIM_W-1:0];
         inside_ff <= in_pic;
      end
   end

   always_comb begin
      prod = PROD_W'(sy_ff) * PROD_W'(picture_width);
      lin  = LIN_W'(prod) + LIN_W'(sx_ff);
      hit  = inside_ff && (64'(lin) < 64'(IMAGE_PIXELS));
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         addr_ff    <= lin;
         hit_ff     <= hit;
         inside2_ff <= inside_ff;
      end
   end

   assign lin_addr    = addr_ff;
   assign stat.in_pic = inside2_ff;
   assign stat.hit    = hit_ff;

endmodule

/* hdl/rcis_store.sv */
// ----------------------------------------------------------------------------
// Rotated image sampler image store
// Single-port-write, registered-read pixel memory.
// ----------------------------------------------------------------------------
module rcis_store import rcis_pkg::*; #(
   parameter int IMAGE_PIXELS = 16384,
   parameter int ADDR_W       = 14
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [PIXEL_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [PIXEL_W-1:0] rd_data
);

   logic [PIXEL_W-1:0] store_ff [IMAGE_PIXELS];
   logic [PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/rotated_centered_image_sampler.sv */
// ----------------------------------------------------------------------------
// Rotated, centred image sampler
// Keeps a pixel store and answers framebuffer reads through a rotation and
// centring map; points outside the picture read as black.
//
//   Channel  Direction  Handshake          Moves
//   req_     in         valid / stall      one load or read request
//   rsp_     out        valid / stall      one pixel for each read request
//   csr_     in         valid / ready      one register write
//
// A load request is written to the store at acceptance.
// A read request passes through the mapping, address multiply, store read and
// output handover stages in that order; the handover waits while rsp_ is stalled.
// A new request is taken while an earlier result waits in the output register.
// Reset is synchronous and restores the register defaults; the store is
// not cleared.
// ----------------------------------------------------------------------------
`include "rotated_centered_image_sampler_macros.svh"

module rotated_centered_image_sampler import rcis_pkg::*; #(
   parameter int MAX_DIM      = 1024,
   parameter int IMAGE_PIXELS = 16384
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [KIND_W-1:0]       req_kind,
   input  logic [LOAD_INDEX_W-1:0] req_load_index,
   input  logic [PIXEL_W-1:0]      req_load_value,
   input  logic [POS_W-1:0]        req_pos_x,
   input  logic [POS_W-1:0]        req_pos_y,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PIXEL_W-1:0]      rsp_pixel_out,
   output logic                    rsp_inside_image,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0]       csr_data
);

   localparam int DIM_W     = ($clog2(MAX_DIM + 1) > SIZE_RST_W) ?
                              $clog2(MAX_DIM + 1) : SIZE_RST_W;
   localparam int ADDR_W    = $clog2(IMAGE_PIXELS);
   localparam int PROD_W    = 2 * DIM_W + 1;
   localparam int LIN_W     = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;
   localparam int IDX_EXT_W = (ADDR_W > LOAD_INDEX_W) ? ADDR_W : LOAD_INDEX_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MAP  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]             state_ff;
   logic [2:0]             state_in;
   logic [POS_W-1:0]       pos_x_ff;
   logic [POS_W-1:0]       pos_y_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [PIXEL_W-1:0]     rsp_pixel_ff;
   logic                   rsp_inside_ff;

   logic                   req_accept;
   logic                   out_free;
   logic                   out_load;
   logic                   mem_wr_en;
   logic [IDX_EXT_W-1:0]   idx_ext;
   logic [PIXEL_W-1:0]     rd_data;
   logic [LIN_W-1:0]       lin_addr;
   map_ctrl_type           map_ctrl;
   map_stat_type           map_stat;

   logic [DIM_W-1:0]       frame_width;
   logic [DIM_W-1:0]       frame_height;
   logic [ROT_W-1:0]       rotation_mode;
   logic [DIM_W-1:0]       picture_width;
   logic [DIM_W-1:0]       picture_height;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign out_load   = (state_ff == S_DONE) && out_free;

   assign idx_ext   = IDX_EXT_W'(req_load_index);
   assign mem_wr_en = req_accept && (req_kind == KIND_LOAD) &&
                      (32'(req_load_index) < 32'(IMAGE_PIXELS));

   assign map_ctrl.map_en = (state_ff == S_MAP);
   assign map_ctrl.mul_en = (state_ff == S_MUL);

   rcis_csr #(
      .MAX_DIM (MAX_DIM),
      .DIM_W   (DIM_W)
   ) u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .frame_width    (frame_width),
      .frame_height   (frame_height),
      .rotation_mode  (rotation_mode),
      .picture_width  (picture_width),
      .picture_height (picture_height)
   );

   rcis_map #(
      .DIM_W        (DIM_W),
      .LIN_W        (LIN_W),
      .IMAGE_PIXELS (IMAGE_PIXELS)
   ) u_map (
      .clock          (clock),
      .ctrl           (map_ctrl),
      .pos_x          (pos_x_ff),
      .pos_y          (pos_y_ff),
      .frame_width    (frame_width),
      .frame_height   (frame_height),
      .rotation_mode  (rotation_mode),
      .picture_width  (picture_width),
      .picture_height (picture_height),
      .lin_addr       (lin_addr),
      .stat           (map_stat)
   );

   rcis_store #(
      .IMAGE_PIXELS (IMAGE_PIXELS),
      .ADDR_W       (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (idx_ext[ADDR_W-1:0]),
      .wr_data (req_load_value),
      .rd_en   (state_ff == S_READ),
      .rd_addr (lin_addr[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_kind == KIND_READ)) begin
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
      end
      if (out_load) begin
         rsp_pixel_ff  <= map_stat.hit ? rd_data : BLACK;
         rsp_inside_ff <= map_stat.in_pic;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = rsp_pixel_ff;
   assign rsp_inside_image = rsp_inside_ff;

   `RCIS_ASSERT_SAME(a_store_write_idle, clock, reset, mem_wr_en, state_ff == S_IDLE,
                     "store written while a read request is in flight")
   `RCIS_ASSERT_SAME(a_result_from_done, clock, reset, $rose(rsp_valid_ff),
                     $past(state_ff) == S_DONE, "result appeared without a completed read")
   `RCIS_ASSERT_SAME(a_outside_black, clock, reset, rsp_valid_ff && !rsp_inside_ff,
                     rsp_pixel_ff == BLACK, "pixel outside the picture is not black")
   `RCIS_ASSERT_NEXT(a_done_handover, clock, reset, out_load,
                     rsp_valid_ff && (state_ff == S_IDLE),
                     "finished read not handed to the output register")

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotated image sampler testbench
// Loads pixels into the store and reads framebuffer points under every rotation
// and a set of centring and size settings, from a short hand-written table and
// then from random traffic with random gaps and back-pressure; each response is
// checked against the table or against a predictor kept inside this bench.
// ----------------------------------------------------------------------------
module tb;
   import rcis_pkg::*;

   localparam int MAX_DIM      = 1024;
   localparam int IMAGE_PIXELS = 16384;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 24;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [LOAD_INDEX_W-1:0] index;
      logic [PIXEL_W-1:0]      value;
      logic [POS_W-1:0]        x;
      logic [POS_W-1:0]        y;
      logic                    typed;
      logic [PIXEL_W-1:0]      pixel;
      logic                    in_pic;
   } stim_row_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               in_pic;
   } pixel_result_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [KIND_W-1:0]       req_kind;
   logic [LOAD_INDEX_W-1:0] req_load_index;
   logic [PIXEL_W-1:0]      req_load_value;
   logic [POS_W-1:0]        req_pos_x;
   logic [POS_W-1:0]        req_pos_y;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [PIXEL_W-1:0]      rsp_pixel_out;
   logic                    rsp_inside_image;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [SIZE_W-1:0]       csr_data;

   int frame_w, frame_h, pic_w, pic_h;
   logic [ROT_W-1:0] rot_mode;
   logic [PIXEL_W-1:0] image_copy [IMAGE_PIXELS];
   bit loaded [IMAGE_PIXELS];
   pixel_result_type pending_pixels [$];
   stim_row_type directed_rows [19];
   logic [SIZE_W-1:0] phase_cfg [10][5];

   int recent_addr = -1;
   bit idle_on = 1'b1;
   int mismatches = 0;
   int loads_done = 0;
   int reads_done = 0;
   int pixels_checked = 0;
   int settings_done = 0;
   int quiet_cycles = 0;
   int stall_left = 0;

   rotated_centered_image_sampler #(
      .MAX_DIM(MAX_DIM),
      .IMAGE_PIXELS(IMAGE_PIXELS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_load_index(req_load_index),
      .req_load_value(req_load_value),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_inside_image(rsp_inside_image),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic int idle_len();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic int clamp_size(input logic [SIZE_W-1:0] v);
      return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
   endfunction

   function automatic void centre_offsets(output int off_x, output int off_y);
      int scr_w, scr_h;
      scr_w = rot_mode[0] ? frame_h : frame_w;
      scr_h = rot_mode[0] ? frame_w : frame_h;
      off_x = (scr_w - pic_w) / 2;
      off_y = (scr_h - pic_h) / 2;
   endfunction

   function automatic void locate(input int x, input int y, output bit hit, output int addr);
      int off_x, off_y, sx, sy;
      hit = 1'b0;
      addr = 0;
      if (x >= frame_w || y >= frame_h) return;
      centre_offsets(off_x, off_y);
      case (rot_mode)
         ROT_CW: begin
            sx = frame_h - 1 - y;
            sy = x;
         end
         ROT_HALF: begin
            sx = frame_w - 1 - x;
            sy = frame_h - 1 - y;
         end
         ROT_CCW: begin
            sx = y;
            sy = frame_w - 1 - x;
         end
         default: begin
            sx = x;
            sy = y;
         end
      endcase
      sx -= off_x;
      sy -= off_y;
      if (sx >= 0 && sx < pic_w && sy >= 0 && sy < pic_h) begin
         hit = 1'b1;
         addr = sy * pic_w + sx;
      end
   endfunction

   function automatic pixel_result_type sample_pixel(input int x, input int y);
      pixel_result_type res;
      bit hit;
      int addr;
      locate(x, y, hit, addr);
      res.in_pic = hit;
      res.pixel = (hit && addr < IMAGE_PIXELS) ? image_copy[addr] : BLACK;
      return res;
   endfunction

   function automatic stim_row_type make_row(input logic [KIND_W-1:0] kind, input int index,
                                             input int value, input int x, input int y);
      stim_row_type r;
      r.kind = kind;
      r.index = LOAD_INDEX_W'(index);
      r.value = PIXEL_W'(value);
      r.x = POS_W'(x);
      r.y = POS_W'(y);
      r.typed = 1'b0;
      r.pixel = BLACK;
      r.in_pic = 1'b0;
      return r;
   endfunction

   function automatic stim_row_type typed_read(input int x, input int y, input int pixel,
                                               input logic in_pic);
      stim_row_type r;
      r = make_row(KIND_READ, 0, 0, x, y);
      r.typed = 1'b1;
      r.pixel = PIXEL_W'(pixel);
      r.in_pic = in_pic;
      return r;
   endfunction

   task automatic send_request(input stim_row_type r);
      int gap;
      pixel_result_type want;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= r.kind;
      req_load_index <= r.index;
      req_load_value <= r.value;
      req_pos_x <= r.x;
      req_pos_y <= r.y;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (r.kind == KIND_LOAD) begin
         if (int'(r.index) < IMAGE_PIXELS) begin
            image_copy[r.index] = r.value;
            loaded[r.index] = 1'b1;
         end
         loads_done++;
      end else begin
         if (r.typed) begin
            want.pixel = r.pixel;
            want.in_pic = r.in_pic;
         end else begin
            want = sample_pixel(int'(r.x), int'(r.y));
         end
         pending_pixels.push_back(want);
         reads_done++;
      end
   endtask

   // A point that lands on a store entry never written gets a load first.
   task automatic read_pixel(input stim_row_type r);
      bit hit;
      int addr;
      locate(int'(r.x), int'(r.y), hit, addr);
      if (hit && addr < IMAGE_PIXELS) begin
         if (!loaded[addr])
            send_request(make_row(KIND_LOAD, addr, $urandom_range(0, 65535),
                                  $urandom_range(0, 1023), $urandom_range(0, 1023)));
         recent_addr = addr;
      end
      send_request(r);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [SIZE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_FRAME_WIDTH:    frame_w = clamp_size(data);
         CSR_FRAME_HEIGHT:   frame_h = clamp_size(data);
         CSR_ROTATION_MODE:  rot_mode = data[ROT_W-1:0];
         CSR_PICTURE_WIDTH:  pic_w = clamp_size(data);
         CSR_PICTURE_HEIGHT: pic_h = clamp_size(data);
         default: ;
      endcase
   endtask

   task automatic configure(input logic [SIZE_W-1:0] fw, input logic [SIZE_W-1:0] fh,
                            input logic [SIZE_W-1:0] rot, input logic [SIZE_W-1:0] pw,
                            input logic [SIZE_W-1:0] ph);
      write_register(CSR_FRAME_WIDTH, fw);
      write_register(CSR_FRAME_HEIGHT, fh);
      write_register(CSR_ROTATION_MODE, rot);
      write_register(CSR_PICTURE_WIDTH, pw);
      write_register(CSR_PICTURE_HEIGHT, ph);
      csr_valid <= 1'b0;
      settings_done++;
   endtask

   // Loads give no response, so drain idles on for the last load to land.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      int r, x, y, sx, sy, off_x, off_y;
      repeat (count) begin
         r = $urandom_range(0, 99);
         x = $urandom_range(0, 1023);
         y = $urandom_range(0, 1023);
         if (r < 30) begin
            sx = ($urandom_range(0, 1) == 1 && recent_addr >= 0) ? recent_addr
                                                                 : $urandom_range(0, 16383);
            send_request(make_row(KIND_LOAD, sx, $urandom_range(0, 65535), x, y));
         end else begin
            if (r < 75 && pic_w > 0 && pic_h > 0) begin
               centre_offsets(off_x, off_y);
               sx = $urandom_range(0, pic_w - 1) + off_x;
               sy = $urandom_range(0, pic_h - 1) + off_y;
               case (rot_mode)
                  ROT_CW: begin
                     sx = sx + 0;
                     {sx, sy} = {sy, frame_h - 1 - sx};
                  end
                  ROT_HALF: begin
                     sx = frame_w - 1 - sx;
                     sy = frame_h - 1 - sy;
                  end
                  ROT_CCW: {sx, sy} = {frame_w - 1 - sy, sx};
                  default: ;
               endcase
               if (sx >= 0 && sx < 1024 && sy >= 0 && sy < 1024) begin
                  x = sx;
                  y = sy;
               end
            end else if (r < 90 && frame_w > 0 && frame_h > 0) begin
               x = $urandom_range(0, frame_w - 1);
               y = $urandom_range(0, frame_h - 1);
            end
            read_pixel(make_row(KIND_READ, $urandom_range(0, 16383),
                                $urandom_range(0, 65535), x, y));
         end
      end
   endtask

   always @(posedge clock) begin : response_side
      pixel_result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("response with no read request outstanding");
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (rsp_pixel_out !== want.pixel)
               report_mismatch($sformatf("pixel_out %h, expected %h", rsp_pixel_out,
                                         want.pixel));
            if (rsp_inside_image !== want.in_pic)
               report_mismatch($sformatf("inside_image %b, expected %b", rsp_inside_image,
                                         want.in_pic));
         end
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = idle_len();
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
          (csr_valid === 1'b1 && csr_ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_LOAD;
      req_load_index = '0;
      req_load_value = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      csr_valid = 1'b0;
      csr_index = CSR_FRAME_WIDTH;
      csr_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      frame_w = FRAME_WIDTH_RST;
      frame_h = FRAME_HEIGHT_RST;
      rot_mode = ROT_NONE;
      pic_w = PICTURE_WIDTH_RST;
      pic_h = PICTURE_HEIGHT_RST;

      // After reset the picture sits at column 96, row 56 of the framebuffer.
      directed_rows = '{
         make_row(KIND_LOAD, 0, 16'hFFFF, 0, 0),
         make_row(KIND_LOAD, 16383, 16'h0001, 1023, 1023),
         make_row(KIND_LOAD, 1, 16'h8000, 0, 0),
         make_row(KIND_LOAD, 128, 16'h5A5A, 0, 0),
         make_row(KIND_LOAD, 2, 16'h0000, 0, 0),
         typed_read(96, 56, 16'hFFFF, 1'b1),
         typed_read(223, 183, 16'h0001, 1'b1),
         typed_read(97, 56, 16'h8000, 1'b1),
         typed_read(96, 57, 16'h5A5A, 1'b1),
         typed_read(98, 56, 16'h0000, 1'b1),
         typed_read(95, 56, BLACK, 1'b0),
         typed_read(96, 55, BLACK, 1'b0),
         typed_read(224, 183, BLACK, 1'b0),
         typed_read(319, 239, BLACK, 1'b0),
         typed_read(320, 0, BLACK, 1'b0),
         typed_read(0, 240, BLACK, 1'b0),
         typed_read(1023, 1023, BLACK, 1'b0),
         make_row(KIND_LOAD, 16383, 16'hAAAA, 0, 0),
         make_row(KIND_READ, 0, 0, 223, 183)
      };
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == KIND_LOAD)
            send_request(directed_rows[i]);
         else
            read_pixel(directed_rows[i]);
      end
      drain();

      // Oversized sizes clamp to the maximum; zero sizes leave everything black.
      phase_cfg = '{
         '{11'd320, 11'd240, {9'd0, ROT_CW}, 11'd128, 11'd128},
         '{11'd320, 11'd240, {9'd0, ROT_HALF}, 11'd100, 11'd60},
         '{11'd240, 11'd320, {9'd0, ROT_CCW}, 11'd127, 11'd33},
         '{11'd1024, 11'd1024, {9'd0, ROT_NONE}, 11'd1024, 11'd1024},
         '{11'd2047, 11'd1500, {9'h1FF, ROT_CW}, 11'd2047, 11'd16},
         '{11'd1, 11'd1, {9'h0AA, ROT_HALF}, 11'd1, 11'd1},
         '{11'd64, 11'd48, {9'd0, ROT_CCW}, 11'd0, 11'd0},
         '{11'd0, 11'd0, {9'd0, ROT_NONE}, 11'd8, 11'd8},
         '{11'd16, 11'd10, {9'd0, ROT_CW}, 11'd200, 11'd81},
         '{11'd101, 11'd77, {9'h155, ROT_NONE}, 11'd50, 11'd30}
      };
      foreach (phase_cfg[p]) begin
         configure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3],
                   phase_cfg[p][4]);
         idle_on = ($urandom_range(0, 3) != 0);
         run_random(PHASE_ITEMS);
         drain();
      end
      repeat (4) begin
         if ($urandom_range(0, 3) == 0)
            configure(SIZE_W'($urandom_range(0, 2047)), SIZE_W'($urandom_range(0, 2047)),
                      SIZE_W'($urandom_range(0, 2047)), SIZE_W'($urandom_range(0, 2047)),
                      SIZE_W'($urandom_range(0, 2047)));
         else
            configure(SIZE_W'($urandom_range(1, 400)), SIZE_W'($urandom_range(1, 400)),
                      SIZE_W'($urandom_range(0, 3)), SIZE_W'($urandom_range(1, 200)),
                      SIZE_W'($urandom_range(1, 200)));
         idle_on = ($urandom_range(0, 3) != 0);
         run_random(PHASE_ITEMS);
         drain();
      end

      $display("%0d pixel loads and %0d framebuffer reads over %0d register settings,",
               loads_done, reads_done, settings_done);
      $display("%0d responses compared, %0d mismatches", pixels_checked, mismatches);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/rcis_pkg.sv
hdl/rcis_csr.sv
hdl/rcis_map.sv
hdl/rcis_store.sv
hdl/rotated_centered_image_sampler.sv
test/tb.sv
